/* hdl/lqps_pkg.sv */
// Shared types, constants and sizes for the link quality parent selector.
package lqps_pkg;

    localparam int NEIGHBORS = 32;
    localparam int IDX_W     = $clog2(NEIGHBORS);
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam int QUAL_W    = 14;
    localparam int QINIT_W   = 10;

    localparam logic [1:0] FUNC_LINK  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] CFG_OWN_ADDRESS     = 2'd0;
    localparam logic [1:0] CFG_ROUTE_PERIOD    = 2'd1;
    localparam logic [1:0] CFG_HOP_PENALTY     = 2'd2;
    localparam logic [1:0] CFG_INITIAL_QUALITY = 2'd3;

    localparam logic [7:0]  RST_OWN_ADDRESS     = 8'd1;
    localparam logic [6:0]  RST_ROUTE_PERIOD    = 7'd10;
    localparam logic [15:0] RST_HOP_PENALTY     = 16'd5;
    localparam logic [6:0]  RST_INITIAL_QUALITY = 7'd10;

    localparam logic [15:0] GAP_CAP        = 16'd50;
    localparam logic [15:0] COST_CAP       = 16'd400;
    localparam logic [16:0] COST_AGE       = 17'd8;
    localparam logic [15:0] NO_ROUTE_COST  = 16'd401;
    localparam logic [7:0]  NO_ROUTE_LEVEL = 8'h7d;
    localparam logic [7:0]  NO_PARENT      = 8'hff;
    localparam logic [15:0] RESET_COST     = 16'h3fff;
    localparam logic [7:0]  RESET_LEVEL    = 8'h7f;
    // low byte of the 11-bit neighbor reset level 0x3ff; upper bits never reach an output
    localparam logic [7:0]  RESET_NB_LEVEL = 8'hff;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_LINK,
        OP_TICK,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] idx;
        logic [15:0]      seq;
        logic [7:0]       lvl;
        logic [15:0]      cost;
    } item_t;

    typedef struct packed {
        logic [15:0]       seq;
        logic [QUAL_W-1:0] qual;
        logic [7:0]        lvl;
        logic [15:0]       cost;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [7:0]  own_address;
        logic [6:0]  route_period;
        logic [15:0] hop_penalty;
        logic [6:0]  initial_quality;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* hdl/lqps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/lqps_front.sv */
// Front end: takes input beats and classifies them into queue items.
module lqps_front (
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [47:0]            s_tdata,  // sender, seq_number, hop_level, link_cost
    input  logic [7:0]             s_tuser,  // func, zero pad
    input  lqps_pkg::queue_status_t qstat,
    output logic                   push,
    output lqps_pkg::item_t        item
);
    import lqps_pkg::*;

    logic [7:0] sender;
    logic       sender_in_range;

    assign sender          = s_tdata[7:0];
    // signed index: negative never hits the table
    assign sender_in_range = !sender[7] && (int'(sender[6:0]) < NEIGHBORS);

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && !qstat.full;

    always_comb begin
        item.idx  = sender[IDX_W-1:0];
        item.seq  = s_tdata[23:8];
        item.lvl  = s_tdata[31:24];
        item.cost = s_tdata[47:32];
        unique case (s_tuser[1:0])
            FUNC_LINK:  item.op = sender_in_range ? OP_LINK : OP_NOP;
            FUNC_TICK:  item.op = OP_TICK;
            FUNC_CLEAR: item.op = OP_CLEAR;
            default:    item.op = OP_NOP;
        endcase
    end

endmodule

/* hdl/lqps_queue.sv */
// Short FIFO of classified items between front and back end.
module lqps_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  lqps_pkg::item_t         push_item,
    input  logic                    pop,
    output lqps_pkg::item_t         head,
    output lqps_pkg::queue_status_t qstat
);
    import lqps_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/lqps_back.sv */
// Back end: neighbor table, link update, route scan and result register.
module lqps_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  lqps_pkg::cfg_t  cfg,
    input  logic            head_valid,
    input  lqps_pkg::item_t head,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,  // best_parent, own_level, own_route_cost
    output logic [7:0]      m_tuser   // sender_ok, route_recomputed, zero pad
);
    import lqps_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LINK,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    item_t                item_reg;
    logic [NEIGHBORS-1:0] valid_reg;
    logic [QINIT_W-1:0]   qinit_reg;
    logic [6:0]           countdown_reg;
    logic [7:0]           cur_parent_reg;
    logic [7:0]           cur_level_reg;
    logic [15:0]          cur_cost_reg;
    logic [IDX_W-1:0]     proc_idx_reg;
    logic [7:0]           best_name_reg;
    logic [7:0]           best_level_reg;
    logic [15:0]          best_cost_reg;
    logic                 ok_reg;
    logic                 rescan_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_tdata_reg;
    logic [1:0]           m_flags_reg;

    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic             we;
    entry_t           wentry;
    entry_t           rd_entry;
    entry_t           ent;
    logic [IDX_W-1:0] ent_idx;
    logic [15:0]      gap_raw;
    logic [15:0]      gap;
    logic [QUAL_W-1:0] q_keep;
    logic [QUAL_W-1:0] q_new;
    logic [15:0]      path;
    logic [16:0]      aged_raw;
    logic [15:0]      aged;
    logic             skip;
    logic             win;
    logic             last;
    logic [7:0]       best_name_next;
    logic [7:0]       best_level_next;
    logic [15:0]      best_cost_next;

    lqps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NEIGHBORS)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    assign pop = (state_reg == ST_IDLE) && head_valid;

    // read next slot while the current one is processed
    assign raddr = (state_reg == ST_IDLE) ? ((head.op == OP_LINK) ? head.idx : '0)
                                          : proc_idx_reg + 1'b1;

    assign ent_idx = (state_reg == ST_LINK) ? item_reg.idx : proc_idx_reg;

    // slot never written since clear reads as its reset contents
    always_comb begin
        if (valid_reg[ent_idx]) begin
            ent = rd_entry;
        end else begin
            ent.seq  = '0;
            ent.qual = QUAL_W'(qinit_reg);
            ent.lvl  = RESET_NB_LEVEL;
            ent.cost = RESET_COST;
        end
    end

    // link update
    assign gap_raw = item_reg.seq - ent.seq;
    assign gap     = (gap_raw > GAP_CAP) ? GAP_CAP : gap_raw;
    assign q_keep  = ent.qual - (ent.qual >> 3);
    assign q_new   = q_keep + gap[QUAL_W-1:0];

    // route scan
    assign path     = ent.cost + 16'(ent.qual) + cfg.hop_penalty;
    assign aged_raw = {1'b0, ent.cost} + COST_AGE;
    assign aged     = (aged_raw[15:0] > COST_CAP) ? COST_CAP : aged_raw[15:0];
    assign skip     = (8'(proc_idx_reg) == cfg.own_address);
    assign win      = !skip && (path < best_cost_reg);
    assign last     = (proc_idx_reg == IDX_W'(NEIGHBORS - 1));

    assign best_name_next  = win ? 8'(proc_idx_reg) : best_name_reg;
    assign best_level_next = win ? ent.lvl : best_level_reg;
    assign best_cost_next  = win ? path : best_cost_reg;

    always_comb begin
        we     = 1'b0;
        waddr  = proc_idx_reg;
        wentry = ent;
        unique case (state_reg)
            ST_LINK: begin
                we          = 1'b1;
                waddr       = item_reg.idx;
                wentry.seq  = item_reg.seq;
                wentry.qual = q_new;
                wentry.lvl  = item_reg.lvl;
                wentry.cost = item_reg.cost;
            end
            ST_SCAN: begin
                we          = !skip;
                wentry.cost = aged;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            qinit_reg      <= {RST_INITIAL_QUALITY, 3'b000};
            countdown_reg  <= '0;
            cur_parent_reg <= NO_PARENT;
            cur_level_reg  <= RESET_LEVEL;
            cur_cost_reg   <= RESET_COST;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // in ST_DONE the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (head_valid) begin
                        item_reg   <= head;
                        ok_reg     <= 1'b0;
                        rescan_reg <= 1'b0;
                        unique case (head.op)
                            OP_LINK: begin
                                state_reg <= ST_LINK;
                            end
                            OP_TICK: begin
                                if (countdown_reg != '0) begin
                                    countdown_reg <= countdown_reg - 1'b1;
                                    state_reg     <= ST_DONE;
                                end else begin
                                    countdown_reg  <= cfg.route_period;
                                    proc_idx_reg   <= '0;
                                    best_name_reg  <= NO_PARENT;
                                    best_level_reg <= NO_ROUTE_LEVEL;
                                    best_cost_reg  <= NO_ROUTE_COST;
                                    state_reg      <= ST_SCAN;
                                end
                            end
                            OP_CLEAR: begin
                                valid_reg      <= '0;
                                qinit_reg      <= {cfg.initial_quality, 3'b000};
                                countdown_reg  <= '0;
                                cur_parent_reg <= NO_PARENT;
                                cur_level_reg  <= RESET_LEVEL;
                                cur_cost_reg   <= RESET_COST;
                                state_reg      <= ST_DONE;
                            end
                            OP_NOP: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_LINK: begin
                    valid_reg[item_reg.idx] <= 1'b1;
                    ok_reg                  <= 1'b1;
                    state_reg               <= ST_DONE;
                end
                ST_SCAN: begin
                    if (!skip) begin
                        valid_reg[proc_idx_reg] <= 1'b1;
                    end
                    best_name_reg  <= best_name_next;
                    best_level_reg <= best_level_next;
                    best_cost_reg  <= best_cost_next;
                    if (last) begin
                        cur_parent_reg <= best_name_next;
                        cur_level_reg  <= best_level_next + 8'd1;
                        cur_cost_reg   <= best_cost_next;
                        rescan_reg     <= 1'b1;
                        state_reg      <= ST_DONE;
                    end else begin
                        proc_idx_reg <= proc_idx_reg + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {cur_cost_reg, cur_level_reg, cur_parent_reg};
                        m_flags_reg  <= {rescan_reg, ok_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = {6'b000000, m_flags_reg};

endmodule

/* hdl/link_quality_parent_selector.sv */
// Top level of the link quality parent selector: config registers, front, queue, back.

// Keeps a 32-slot neighbor table (sequence number, smoothed link quality,
// advertised level and cost) and picks the lowest-cost parent. Each input
// beat gives exactly one result beat carrying the current route. A link update
// to a slot in the table goes through a table read, a read-modify-write and an
// output load; a route tick that rescans walks all NEIGHBORS slots, the single
// read port of the table RAM visiting one slot per cycle; a tick that only counts
// down, a clear, an off-table link update and an unused func go straight to the
// output load.
// A two-entry queue sits between input and table logic, so input beats are
// still taken, until it is full, while a scan runs or a result waits on m_tready.
// Clear is instant: slots carry valid flops and read as reset contents until written.
module link_quality_parent_selector (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // sender, seq_number, hop_level, link_cost
    input  logic [7:0]  s_tuser,  // func, zero pad
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // best_parent, own_level, own_route_cost
    output logic [7:0]  m_tuser   // sender_ok, route_recomputed, zero pad
);
    import lqps_pkg::*;

    cfg_t          cfg_reg;
    queue_status_t qstat;
    logic          push;
    item_t         push_item;
    item_t         head;
    logic          pop;

    // config registers; the user must write them only while the block is idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address     <= RST_OWN_ADDRESS;
            cfg_reg.route_period    <= RST_ROUTE_PERIOD;
            cfg_reg.hop_penalty     <= RST_HOP_PENALTY;
            cfg_reg.initial_quality <= RST_INITIAL_QUALITY;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_OWN_ADDRESS:     cfg_reg.own_address     <= cfg_wdata[7:0];
                CFG_ROUTE_PERIOD:    cfg_reg.route_period    <= cfg_wdata[6:0];
                CFG_HOP_PENALTY:     cfg_reg.hop_penalty     <= cfg_wdata;
                CFG_INITIAL_QUALITY: cfg_reg.initial_quality <= cfg_wdata[6:0];
            endcase
        end
    end

    // classify beats: a link update from an out-of-table sender becomes a no-op
    lqps_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .qstat    (qstat),
        .push     (push),
        .item     (push_item)
    );

    lqps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // table, scan sequencer and output register
    lqps_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (!qstat.empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    // queue cannot be full and empty at once
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty");

    // the two flags never come together
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("sender_ok and route_recomputed both set");

    // a rescanned route never costs more than the no-route value
    a_scan_cost_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[31:16] <= NO_ROUTE_COST))
        else $error("rescanned route cost above bound");

    // a rescan with no winner reports the no-route level and cost
    a_no_route: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1] && (m_tdata[7:0] == NO_PARENT))
            |-> ((m_tdata[15:8] == NO_ROUTE_LEVEL + 8'd1)
                 && (m_tdata[31:16] == NO_ROUTE_COST)))
        else $error("no-route result inconsistent");

endmodule
